FILE: hw/rtl/xxbd_pkg.sv
`timescale 1ns / 1ps

package xxbd_pkg;

  // Fixed widths of the data and configuration paths
  localparam int WORD_W  = 32;
  localparam int CFG_IW  = 3;
  localparam int ROUND_W = 6;

  // Width of the block length as seen by the round table
  localparam int LEN_W = 7;

  // Reset value of the per-round sum constant
  localparam logic [WORD_W-1:0] DELTA_RESET = 32'h6761_6C66;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] REG_KEY0  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_KEY1  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_KEY2  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_KEY3  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_DELTA = 3'd4;

  // Store read address selection
  typedef logic [2:0] rd_sel_t;
  localparam rd_sel_t RD_ZERO = 3'd0;
  localparam rd_sel_t RD_LAST = 3'd1;
  localparam rd_sel_t RD_PM1  = 3'd2;
  localparam rd_sel_t RD_PM2  = 3'd3;
  localparam rd_sel_t RD_P    = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    accept;
    logic    load_q;
    logic    load_y_sum;
    logic    start_round;
    logic    load_cur;
    logic    do_mix;
    logic    do_wr;
    logic    do_zmix;
    logic    do_zwr;
    logic    clr_p;
    logic    out_read;
    logic    finish;
    rd_sel_t rd_sel;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic len_short;
    logic round_done;
    logic p_is_one;
    logic out_last;
  } sts_t;

  // Round count 6 + 52/len for a block of len >= 2 words
  function automatic logic [ROUND_W-1:0] xxbd_rounds(input logic [LEN_W-1:0] len);
    logic [ROUND_W-1:0] q;
    case (len) inside
      7'd2:              q = 6'd32;
      7'd3:              q = 6'd23;
      7'd4:              q = 6'd19;
      7'd5:              q = 6'd16;
      7'd6:              q = 6'd14;
      7'd7:              q = 6'd13;
      7'd8:              q = 6'd12;
      [7'd9:7'd10]:      q = 6'd11;
      [7'd11:7'd13]:     q = 6'd10;
      [7'd14:7'd17]:     q = 6'd9;
      [7'd18:7'd26]:     q = 6'd8;
      [7'd27:7'd52]:     q = 6'd7;
      default:           q = 6'd6;
    endcase
    return q;
  endfunction

  // XXTEA mixing function
  function automatic logic [WORD_W-1:0] xxbd_mix(input logic [WORD_W-1:0] z,
                                                 input logic [WORD_W-1:0] y,
                                                 input logic [WORD_W-1:0] sum,
                                                 input logic [WORD_W-1:0] k);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    b = (sum ^ y) + (k ^ z);
    return a ^ b;
  endfunction

endpackage

FILE: hw/rtl/xxbd_ram.sv
`timescale 1ns / 1ps

module xxbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/xxbd_datapath.sv
`timescale 1ns / 1ps

module xxbd_datapath
  import xxbd_pkg::*;
#(
  parameter int MAX_WORDS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [WORD_W-1:0]   in_word,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [WORD_W-1:0]   cfg_data,
  output logic                out_strobe,
  output logic [WORD_W-1:0]   out_plain_word,
  output logic                out_block_end,
  output logic                out_overflowed
);

  localparam int AW = $clog2(MAX_WORDS);
  localparam int CW = $clog2(MAX_WORDS + 1);

  logic [WORD_W-1:0]  key_r [4];
  logic [WORD_W-1:0]  delta_r;
  logic [CW-1:0]      cnt_r;
  logic               ovf_r;
  logic [AW-1:0]      p_r;
  logic [ROUND_W-1:0] rnd_r;
  logic [WORD_W-1:0]  sum_r;
  logic [WORD_W-1:0]  y_r;
  logic [WORD_W-1:0]  cur_r;
  logic [WORD_W-1:0]  z_r;
  logic [WORD_W-1:0]  zlast_r;
  logic [WORD_W-1:0]  mix_r;
  logic               pend_r;
  logic               pend_last_r;

  logic               full;
  logic [AW-1:0]      last;
  logic [1:0]         e;
  logic [WORD_W-1:0]  new_word;
  logic [WORD_W-1:0]  rd_data;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [WORD_W-1:0]  wr_data;

  assign full     = (cnt_r >= CW'(MAX_WORDS));
  assign last     = AW'(cnt_r - CW'(1));
  assign e        = sum_r[3:2];
  assign new_word = cur_r - mix_r;

  // Status toward the controller
  assign sts.len_short  = (cnt_r < CW'(2));
  assign sts.round_done = (rnd_r == '0) || (sum_r == '0);
  assign sts.p_is_one   = (p_r == AW'(1));
  assign sts.out_last   = (p_r == last);

  // Select the store read address
  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_LAST: rd_addr = last;
      RD_PM1:  rd_addr = p_r - AW'(1);
      RD_PM2:  rd_addr = p_r - AW'(2);
      RD_P:    rd_addr = p_r;
      default: rd_addr = '0;
    endcase
  end

  // Store port: incoming words, then updated words of each round
  always_comb begin
    wr_en   = (cmd.accept && !full) || cmd.do_wr || cmd.do_zwr;
    wr_addr = '0;
    wr_data = new_word;
    if (cmd.accept) begin
      wr_addr = cnt_r[AW-1:0];
      wr_data = in_word;
    end else if (cmd.do_wr) begin
      wr_addr = p_r;
    end
  end

  xxbd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_WORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
      delta_r <= DELTA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_r[cfg_index[1:0]] <= cfg_data;
        REG_DELTA:                              delta_r <= cfg_data;
        default:                                ;
      endcase
    end
  end

  // Block bookkeeping and output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.out_read;
      if (cmd.accept) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CW'(1);
        end
      end
      if (cmd.finish) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end
    end
  end

  // Round datapath
  always_ff @(posedge clk) begin
    if (cmd.load_q) begin
      rnd_r <= xxbd_rounds(LEN_W'(cnt_r));
    end
    if (cmd.load_y_sum) begin
      y_r   <= rd_data;
      sum_r <= delta_r * {{(WORD_W-ROUND_W){1'b0}}, rnd_r};
    end
    if (cmd.start_round) begin
      p_r <= last;
    end
    if (cmd.load_cur) begin
      cur_r <= rd_data;
    end
    if (cmd.do_mix) begin
      z_r   <= rd_data;
      mix_r <= xxbd_mix(rd_data, y_r, sum_r, key_r[2'(p_r) ^ e]);
    end
    if (cmd.do_wr) begin
      y_r   <= new_word;
      cur_r <= z_r;
      p_r   <= p_r - AW'(1);
      if (p_r == last) begin
        zlast_r <= new_word;
      end
    end
    if (cmd.do_zmix) begin
      mix_r <= xxbd_mix(zlast_r, y_r, sum_r, key_r[e]);
    end
    if (cmd.do_zwr) begin
      y_r   <= new_word;
      sum_r <= sum_r - delta_r;
      rnd_r <= rnd_r - ROUND_W'(1);
    end
    if (cmd.clr_p) begin
      p_r <= '0;
    end
    if (cmd.out_read) begin
      p_r         <= p_r + AW'(1);
      pend_last_r <= sts.out_last;
    end
  end

  assign out_strobe     = pend_r;
  assign out_plain_word = rd_data;
  assign out_block_end  = pend_last_r;
  assign out_overflowed = ovf_r;

endmodule

FILE: hw/rtl/xxbd_ctrl.sv
`timescale 1ns / 1ps

module xxbd_ctrl
  import xxbd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic final_word,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_LOADY = 4'd2;
  localparam logic [3:0] S_RCHK  = 4'd3;
  localparam logic [3:0] S_RCUR  = 4'd4;
  localparam logic [3:0] S_MIX   = 4'd5;
  localparam logic [3:0] S_WR    = 4'd6;
  localparam logic [3:0] S_ZMIX  = 4'd7;
  localparam logic [3:0] S_ZWR   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign busy = (state_r != S_IDLE);

  // Decode state into datapath commands and next state
  always_comb begin
    cmd       = '0;
    cmd.rd_sel = RD_ZERO;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = start;
        if (start && final_word) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (sts.len_short) begin
          cmd.clr_p = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.load_q = 1'b1;
          cmd.rd_sel = RD_ZERO;
          state_nxt  = S_LOADY;
        end
      end
      S_LOADY: begin
        cmd.load_y_sum = 1'b1;
        state_nxt      = S_RCHK;
      end
      S_RCHK: begin
        if (sts.round_done) begin
          cmd.clr_p = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.start_round = 1'b1;
          cmd.rd_sel      = RD_LAST;
          state_nxt       = S_RCUR;
        end
      end
      S_RCUR: begin
        cmd.load_cur = 1'b1;
        cmd.rd_sel   = RD_PM1;
        state_nxt    = S_MIX;
      end
      S_MIX: begin
        cmd.do_mix = 1'b1;
        state_nxt  = S_WR;
      end
      S_WR: begin
        cmd.do_wr = 1'b1;
        if (sts.p_is_one) begin
          state_nxt = S_ZMIX;
        end else begin
          cmd.rd_sel = RD_PM2;
          state_nxt  = S_MIX;
        end
      end
      S_ZMIX: begin
        cmd.do_zmix = 1'b1;
        state_nxt   = S_ZWR;
      end
      S_ZWR: begin
        cmd.do_zwr = 1'b1;
        state_nxt  = S_RCHK;
      end
      S_OUT: begin
        cmd.out_read = 1'b1;
        cmd.rd_sel   = RD_P;
        if (sts.out_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/xxtea_block_decrypt_unit.sv
`timescale 1ns / 1ps

// XXTEA block decryption unit.
// Input: present in_cipher_word / in_final_word with start; a transaction is
// taken at each edge where start is high and busy is low. Each word is written
// to the store as it is taken, so words of a block may come back to back while
// busy is low. The word with in_final_word set ends the block and raises busy.
// A block of len >= 2 words then runs up to 6 + 52/len rounds; each round is
// a round check, a load of the last word, then a mix and a write per word
// down to word 0 (one store read per step). Setup, the closing round check and
// the first store read come before the first result; a one-word block skips
// the rounds. Results then stream out one per cycle on out_strobe with
// out_block_end on the last word and out_overflowed on all words of a block
// that dropped words past MAX_WORDS. busy falls at the edge that ends the last
// result. The receiver cannot stall: each result shows for exactly one cycle.
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while busy
// is low; the block does not enforce this. Indexes 0..3 are the key words, 4
// the round delta. Reset clears the word count, the overflow flag and the keys,
// and loads the delta with its default; store contents are not cleared.
module xxtea_block_decrypt_unit
  import xxbd_pkg::*;
#(
  parameter int MAX_WORDS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [WORD_W-1:0] in_cipher_word,
  input  logic              in_final_word,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  output logic              out_strobe,
  output logic [WORD_W-1:0] out_plain_word,
  output logic              out_block_end,
  output logic              out_overflowed
);

  cmd_t cmd;
  sts_t sts;

  xxbd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .final_word (in_final_word),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  xxbd_datapath #(
    .MAX_WORDS (MAX_WORDS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_word        (in_cipher_word),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_strobe     (out_strobe),
    .out_plain_word (out_plain_word),
    .out_block_end  (out_block_end),
    .out_overflowed (out_overflowed)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import xxbd_pkg::*;

  localparam int unsigned STORE_DEPTH  = 64;
  localparam int unsigned ROUND_FLOOR  = 6;
  localparam int unsigned ROUND_SCALE  = 52;
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // Unused register indexes; writes there must change nothing
  localparam logic [CFG_IW-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IW-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              fin;
  } cipher_txn_t;

  typedef struct {
    logic [WORD_W-1:0] plain;
    logic              last;
    logic              ovf;
  } plain_txn_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [WORD_W-1:0] in_cipher_word;
  logic              in_final_word;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;
  logic              out_strobe;
  logic [WORD_W-1:0] out_plain_word;
  logic              out_block_end;
  logic              out_overflowed;

  // Shadow copy of the block's registers and word store
  logic [WORD_W-1:0] key_cfg [4];
  logic [WORD_W-1:0] delta_cfg = DELTA_RESET;
  logic [WORD_W-1:0] held_words [STORE_DEPTH];
  int unsigned       held_count = 0;
  logic              held_overflow = 1'b0;

  cipher_txn_t cipher_backlog [$];
  plain_txn_t  plain_due [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  xxtea_block_decrypt_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cipher_word (in_cipher_word),
    .in_final_word  (in_final_word),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_strobe     (out_strobe),
    .out_plain_word (out_plain_word),
    .out_block_end  (out_block_end),
    .out_overflowed (out_overflowed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // XXTEA mixing term for one word update
  function automatic logic [WORD_W-1:0] mix_term(input logic [WORD_W-1:0] z,
                                                 input logic [WORD_W-1:0] y,
                                                 input logic [WORD_W-1:0] sum,
                                                 input logic [WORD_W-1:0] k);
    logic [WORD_W-1:0] shifted;
    logic [WORD_W-1:0] keyed;
    shifted = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    keyed   = (sum ^ y) + (k ^ z);
    return shifted ^ keyed;
  endfunction

  // Decrypt the held block in place; stop early once the sum hits zero
  task automatic run_xxtea_decrypt(input int unsigned len);
    int unsigned       last_idx;
    int unsigned       rounds;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic [1:0]        e;
    last_idx = len - 1;
    rounds   = ROUND_FLOOR + ROUND_SCALE / len;
    sum      = rounds * delta_cfg;
    y        = held_words[0];
    for (int unsigned r = 0; r < rounds && sum != '0; r++) begin
      e = sum[3:2];
      for (int unsigned p = last_idx; p > 0; p--) begin
        z = held_words[p - 1];
        held_words[p] = held_words[p] - mix_term(z, y, sum, key_cfg[2'(p) ^ e]);
        y = held_words[p];
      end
      z = held_words[last_idx];
      held_words[0] = held_words[0] - mix_term(z, y, sum, key_cfg[e]);
      y = held_words[0];
      sum = sum - delta_cfg;
    end
  endtask

  // Store one accepted word; on the final word, decrypt and queue the block
  task automatic absorb_cipher_word(input cipher_txn_t txn);
    plain_txn_t res;
    if (held_count < STORE_DEPTH) begin
      held_words[held_count] = txn.word;
      held_count++;
    end else begin
      held_overflow = 1'b1;
    end
    if (txn.fin) begin
      if (held_count >= 2) run_xxtea_decrypt(held_count);
      for (int unsigned i = 0; i < held_count; i++) begin
        res.plain = held_words[i];
        res.last  = (i + 1 == held_count);
        res.ovf   = held_overflow;
        plain_due.push_back(res);
      end
      held_count    = 0;
      held_overflow = 1'b0;
    end
  endtask

  // Drive one register write and mirror it in the shadow copy
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [WORD_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_KEY0:  key_cfg[0] = val;
      REG_KEY1:  key_cfg[1] = val;
      REG_KEY2:  key_cfg[2] = val;
      REG_KEY3:  key_cfg[3] = val;
      REG_DELTA: delta_cfg = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                               input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3,
                               input logic [WORD_W-1:0] d);
    write_reg(REG_KEY0, k0);
    write_reg(REG_KEY1, k1);
    write_reg(REG_KEY2, k2);
    write_reg(REG_KEY3, k3);
    write_reg(REG_DELTA, d);
    for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++) write_reg(CFG_IW'(i), $urandom());
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_word(input logic [WORD_W-1:0] word, input logic fin);
    cipher_txn_t txn;
    txn.word = word;
    txn.fin  = fin;
    cipher_backlog.push_back(txn);
  endtask

  // Queue a block of random words, with the odd all-zero or all-one word
  task automatic queue_block(input int unsigned len);
    logic [WORD_W-1:0] w;
    for (int unsigned i = 0; i < len; i++) begin
      w = $urandom();
      if ($urandom_range(0, 15) == 0) w = $urandom_range(0, 1) ? '1 : '0;
      push_word(w, i + 1 == len);
    end
  endtask

  // Queue mostly short blocks, some medium, a few long, until the budget is used
  task automatic queue_mixed_blocks(input int unsigned budget);
    int unsigned used;
    int unsigned len;
    used = 0;
    while (used < budget) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: len = $urandom_range(1, 4);
        6, 7, 8:          len = $urandom_range(5, 12);
        default:          len = $urandom_range(13, 40);
      endcase
      queue_block(len);
      used += len;
    end
  endtask

  // Wait for the backlog to drain and every result to arrive, then settle
  task automatic wait_drained;
    while (cipher_backlog.size() != 0 || start || busy || plain_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        absorb_cipher_word(cipher_backlog.pop_front());
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          case ($urandom_range(0, 3))
            0:       gap_left = 0;
            1:       gap_left = $urandom_range(1, 3);
            2:       gap_left = $urandom_range(4, 12);
            default: gap_left = $urandom_range(20, 60);
          endcase
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cipher_backlog.size() != 0) begin
        start          <= 1'b1;
        in_cipher_word <= cipher_backlog[0].word;
        in_final_word  <= cipher_backlog[0].fin;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check each result transaction against the oldest expectation
  always @(posedge clk) begin
    plain_txn_t exp;
    if (rst_n && out_strobe) begin
      if (plain_due.size() == 0) begin
        $error("unexpected result: plain_word %h", out_plain_word);
        error_count++;
      end else begin
        exp = plain_due.pop_front();
        if (out_plain_word !== exp.plain) begin
          $error("plain_word: expected %h, got %h", exp.plain, out_plain_word);
          error_count++;
        end
        if (out_block_end !== exp.last) begin
          $error("block_end: expected %b, got %b", exp.last, out_block_end);
          error_count++;
        end
        if (out_overflowed !== exp.ovf) begin
          $error("overflowed: expected %b, got %b", exp.ovf, out_overflowed);
          error_count++;
        end
      end
    end
  end

  // Abort on a hang
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 4; i++) key_cfg[i] = '0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_cipher_word = '0;
    in_final_word  = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_KEY0;
    cfg_data       = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: single-word pass-through and short blocks at the extremes
    push_word('1, 1'b1);
    push_word('0, 1'b1);
    push_word('0, 1'b0);
    push_word('1, 1'b1);
    push_word('1, 1'b0);
    push_word('0, 1'b0);
    push_word(32'h8000_0001, 1'b1);
    wait_drained();

    // All-ones key and delta
    load_settings('1, '1, '1, '1, '1);
    push_word('1, 1'b0);
    push_word('1, 1'b1);
    queue_block(4);
    wait_drained();

    // Zero delta: no round runs, block comes back unchanged
    load_settings($urandom(), $urandom(), $urandom(), $urandom(), '0);
    queue_block(3);
    wait_drained();

    // Half-range delta: sum is zero at once for two words, after one round for three
    load_settings($urandom(), $urandom(), $urandom(), $urandom(), 32'h8000_0000);
    queue_block(2);
    queue_block(3);
    wait_drained();

    // Random keys, default delta
    load_settings($urandom(), $urandom(), $urandom(), $urandom(), DELTA_RESET);
    queue_mixed_blocks(15);
    wait_drained();

    // Random keys and delta; a block that fills the store exactly
    load_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    queue_block(STORE_DEPTH);
    queue_mixed_blocks(10);
    wait_drained();

    // Overflow: two words past the store depth, the final one among them
    load_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    queue_block(STORE_DEPTH + 2);
    queue_mixed_blocks(10);
    wait_drained();

    // Quarter-range delta: sum reaches zero at once or part way through the rounds
    load_settings($urandom(), $urandom(), $urandom(), $urandom(), 32'h4000_0000);
    queue_mixed_blocks(10);
    wait_drained();

    if (plain_due.size() != 0) begin
      $error("%0d expected results never arrived", plain_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
